// File: rtl/core/gbfs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gbfs_pkg
// Shared types, constants and helpers of the breadth-first search engine.
// ----------------------------------------------------------------------------
package gbfs_pkg;

  localparam int NUM_VERTICES = 32;
  localparam int MAX_EDGES    = 64;
  localparam int FIFO_DEPTH   = 32;

  localparam int VW   = 5;
  localparam int VIW  = (NUM_VERTICES > 2) ? $clog2(NUM_VERTICES) : 1;
  localparam int EAW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ECW  = $clog2(MAX_EDGES + 1);
  localparam int FAW  = $clog2(FIFO_DEPTH);
  localparam int FPW  = FAW + 1;

  localparam logic FUNC_ADD    = 1'b0;
  localparam logic FUNC_SEARCH = 1'b1;
  localparam logic KIND_VISIT  = 1'b0;
  localparam logic KIND_DROP   = 1'b1;

  typedef struct packed {
    logic          func;
    logic [VW-1:0] edge_src;
    logic [VW-1:0] edge_dst;
    logic [VW-1:0] start_vertex;
    logic [VW-1:0] goal_vertex;
  } in_item_t;

  typedef struct packed {
    logic          kind;
    logic [VW-1:0] vertex;
    logic          goal_found;
    logic          last;
  } out_item_t;

  typedef struct packed {
    logic [VW-1:0] src;
    logic [VW-1:0] dst;
  } edge_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic add_edge;
    logic search_init;
    logic deq_issue;
    logic scan_begin;
    logic scan_en;
    logic load_visit;
    logic load_drop;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic add_ok;
    logic store_full;
    logic start_ok;
    logic is_goal;
    logic scan_done;
    logic out_free;
    logic fifo_empty;
  } status_t;

  function automatic logic vtx_ok(input logic [VW-1:0] v);
    return 32'(v) < 32'(NUM_VERTICES);
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/graph_bfs_engine_core.sv
`default_nettype none
// An add-edge transaction is stored directly; an edge that finds the store full is reported
// as a drop through the output register. A search spends most of its time in the serial
// edge-store scan through its single read port, once per dequeued vertex that is not the goal.
// A new transaction is taken only when the sequencer is idle; results leave via an output
// register. Reset (rst_n low) empties store and output.
// ----------------------------------------------------------------------------
// graph_bfs_engine_core
// Breadth-first search over a directed edge store filled in insertion order.
// ----------------------------------------------------------------------------
module graph_bfs_engine_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire gbfs_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output gbfs_pkg::out_item_t      out_data
);

  gbfs_pkg::cmd_t    cmd;
  gbfs_pkg::status_t st;

  gbfs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_data.func),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  gbfs_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// File: rtl/core/gbfs_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gbfs_ctrl
// Sequencer for edge insertion, dequeue, edge-store scan and result emission.
// ----------------------------------------------------------------------------
module gbfs_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_func,
  output logic                   in_ready,
  input  wire gbfs_pkg::status_t st,
  output gbfs_pkg::cmd_t         cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DROP = 3'd1;
  localparam logic [2:0] ST_DEQ  = 3'd2;
  localparam logic [2:0] ST_DEQW = 3'd3;
  localparam logic [2:0] ST_SCAN = 3'd4;
  localparam logic [2:0] ST_EMIT = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       accept;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_func == gbfs_pkg::FUNC_ADD) begin
            if (st.add_ok && st.store_full) begin
              state_nxt = ST_DROP;
            end else if (st.add_ok) begin
              cmd.add_edge = 1'b1;
            end
          end else if (st.start_ok) begin
            cmd.search_init = 1'b1;
            state_nxt       = ST_DEQ;
          end
        end
      end
      ST_DROP: begin
        if (st.out_free) begin
          cmd.load_drop = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_DEQ: begin
        cmd.deq_issue = 1'b1;
        state_nxt     = ST_DEQW;
      end
      ST_DEQW: begin
        // The goal is reported at once, without looking at its neighbours.
        if (st.is_goal) begin
          state_nxt = ST_EMIT;
        end else begin
          cmd.scan_begin = 1'b1;
          state_nxt      = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_en = 1'b1;
        if (st.scan_done) begin
          cmd.scan_en = 1'b0;
          state_nxt   = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // The walk ends at the goal or once the vertex FIFO has run dry.
        if (st.out_free) begin
          cmd.load_visit = 1'b1;
          state_nxt      = (st.is_goal || st.fifo_empty) ? ST_IDLE : ST_DEQ;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/gbfs_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gbfs_dp
// Edge store, vertex FIFO, visited marks, scan pipeline and output register.
// ----------------------------------------------------------------------------
module gbfs_dp (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire gbfs_pkg::in_item_t  in_data,
  input  wire gbfs_pkg::cmd_t      cmd,
  output gbfs_pkg::status_t        st,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output gbfs_pkg::out_item_t      out_data
);

  gbfs_pkg::edge_t               edge_mem [gbfs_pkg::MAX_EDGES];
  logic [gbfs_pkg::VW-1:0]       fifo_mem [gbfs_pkg::FIFO_DEPTH];

  logic [gbfs_pkg::ECW-1:0]      count_r, count_nxt;
  logic [gbfs_pkg::ECW-1:0]      e_r, e_nxt;
  logic                          pend_r, pend_nxt;
  logic [gbfs_pkg::FPW-1:0]      head_r, head_nxt;
  logic [gbfs_pkg::FPW-1:0]      tail_r, tail_nxt;
  logic [gbfs_pkg::NUM_VERTICES-1:0] visited_r, visited_nxt;
  logic [gbfs_pkg::VW-1:0]       goal_r, goal_nxt;
  gbfs_pkg::edge_t               edge_rd_r;
  logic [gbfs_pkg::VW-1:0]       cur_r;
  gbfs_pkg::out_item_t           out_r, out_nxt;
  logic                          out_valid_r, out_valid_nxt;

  logic scan_issue;
  logic enq;
  logic fifo_we;
  logic [gbfs_pkg::FAW-1:0]      fifo_waddr;
  logic [gbfs_pkg::VW-1:0]       fifo_wdata;

  assign scan_issue = cmd.scan_en && (e_r != count_r);

  // A neighbour is enqueued when its edge leaves this vertex, it is unvisited
  // and the FIFO still has room.
  assign enq = pend_r && (edge_rd_r.src == cur_r)
               && gbfs_pkg::vtx_ok(edge_rd_r.dst)
               && !visited_r[gbfs_pkg::VIW'(edge_rd_r.dst)]
               && (32'(tail_r) < 32'(gbfs_pkg::FIFO_DEPTH));

  always_comb begin
    count_nxt     = count_r;
    e_nxt         = e_r;
    pend_nxt      = scan_issue;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    visited_nxt   = visited_r;
    goal_nxt      = goal_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    fifo_we       = 1'b0;
    fifo_waddr    = tail_r[gbfs_pkg::FAW-1:0];
    fifo_wdata    = edge_rd_r.dst;

    if (cmd.add_edge) begin
      count_nxt = count_r + 1'b1;
    end
    if (cmd.search_init) begin
      visited_nxt = '0;
      visited_nxt[gbfs_pkg::VIW'(in_data.start_vertex)] = 1'b1;
      head_nxt    = '0;
      tail_nxt    = gbfs_pkg::FPW'(1);
      goal_nxt    = in_data.goal_vertex;
      fifo_we     = 1'b1;
      fifo_waddr  = '0;
      fifo_wdata  = in_data.start_vertex;
    end
    if (cmd.deq_issue) begin
      head_nxt = head_r + 1'b1;
    end
    if (cmd.scan_begin) begin
      e_nxt = '0;
    end else if (scan_issue) begin
      e_nxt = e_r + 1'b1;
    end
    if (enq) begin
      visited_nxt[gbfs_pkg::VIW'(edge_rd_r.dst)] = 1'b1;
      tail_nxt = tail_r + 1'b1;
      fifo_we  = 1'b1;
    end
    if (cmd.load_visit) begin
      out_nxt.kind       = gbfs_pkg::KIND_VISIT;
      out_nxt.vertex     = cur_r;
      out_nxt.goal_found = (cur_r == goal_r);
      out_nxt.last       = (cur_r == goal_r) || (head_r == tail_r);
      out_valid_nxt      = 1'b1;
    end else if (cmd.load_drop) begin
      out_nxt.kind       = gbfs_pkg::KIND_DROP;
      out_nxt.vertex     = '0;
      out_nxt.goal_found = 1'b0;
      out_nxt.last       = 1'b1;
      out_valid_nxt      = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.add_edge) begin
      edge_mem[count_r[gbfs_pkg::EAW-1:0]] <= '{src: in_data.edge_src, dst: in_data.edge_dst};
    end
    if (scan_issue) begin
      edge_rd_r <= edge_mem[e_r[gbfs_pkg::EAW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (fifo_we) begin
      fifo_mem[fifo_waddr] <= fifo_wdata;
    end
    if (cmd.deq_issue) begin
      cur_r <= fifo_mem[head_r[gbfs_pkg::FAW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      e_r         <= '0;
      pend_r      <= 1'b0;
      head_r      <= '0;
      tail_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      e_r         <= e_nxt;
      pend_r      <= pend_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    visited_r <= visited_nxt;
    goal_r    <= goal_nxt;
    out_r     <= out_nxt;
  end

  assign st.add_ok     = gbfs_pkg::vtx_ok(in_data.edge_src) && gbfs_pkg::vtx_ok(in_data.edge_dst);
  assign st.store_full = (32'(count_r) >= 32'(gbfs_pkg::MAX_EDGES));
  assign st.start_ok   = gbfs_pkg::vtx_ok(in_data.start_vertex);
  assign st.is_goal    = (cur_r == goal_r);
  assign st.scan_done  = (e_r == count_r) && !pend_r;
  assign st.out_free   = !out_valid_r || out_ready;
  assign st.fifo_empty = (head_r == tail_r);

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire
